### rtl/mdt_pkg.sv
// mdt_pkg: shared types and constants for the MPPT duty tracker.
// Register map indexes, configuration struct and its reset values.
// No dependencies.
package mdt_pkg;

	localparam int unsigned CFG_AW = 5;

	typedef enum logic [2:0] {
		REG_MODE      = 3'd0,
		REG_INIT_DUTY = 3'd1,
		REG_PWR_CUT   = 3'd2,
		REG_OPT_VOLT  = 3'd3,
		REG_STEP_NEAR = 3'd4,
		REG_STEP_MID  = 3'd5,
		REG_STEP_FAR  = 3'd6
	} reg_idx_t;

	typedef enum logic {
		MODE_INC_COND = 1'b0,
		MODE_PERTURB  = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [6:0]  initial_duty;
		logic [31:0] power_cutoff_uw;
		logic [15:0] optimum_voltage_mv;
		logic [3:0]  step_near;
		logic [3:0]  step_mid;
		logic [3:0]  step_far;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		mode:               MODE_PERTURB,
		initial_duty:       7'd20,
		power_cutoff_uw:    32'd95000000,
		optimum_voltage_mv: 16'd17800,
		step_near:          4'd2,
		step_mid:           4'd2,
		step_far:           4'd2
	};

	// first-sample duty floor
	localparam logic [6:0] DUTY_FIRST_FLOOR = 7'd20;

	localparam logic signed [1:0] DIR_UP   = 2'sb01;
	localparam logic signed [1:0] DIR_HOLD = 2'sb00;
	localparam logic signed [1:0] DIR_DOWN = 2'sb11;

endpackage

### rtl/mdt_regs.sv
// mdt_regs: APB-style configuration register file for the duty tracker.
// Depends on mdt_pkg (register indexes, cfg_t, reset values).
module mdt_regs import mdt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg,
	output logic              rearm
);

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
	assign rearm  = wr_en && (idx == REG_INIT_DUTY);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_MODE:      cfg_q.mode               <= mode_t'(pwdata[0]);
				REG_INIT_DUTY: cfg_q.initial_duty       <= pwdata[6:0];
				REG_PWR_CUT:   cfg_q.power_cutoff_uw    <= pwdata;
				REG_OPT_VOLT:  cfg_q.optimum_voltage_mv <= pwdata[15:0];
				REG_STEP_NEAR: cfg_q.step_near          <= pwdata[3:0];
				REG_STEP_MID:  cfg_q.step_mid           <= pwdata[3:0];
				REG_STEP_FAR:  cfg_q.step_far           <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODE:      prdata = {31'd0, cfg_q.mode};
			REG_INIT_DUTY: prdata = {25'd0, cfg_q.initial_duty};
			REG_PWR_CUT:   prdata = cfg_q.power_cutoff_uw;
			REG_OPT_VOLT:  prdata = {16'd0, cfg_q.optimum_voltage_mv};
			REG_STEP_NEAR: prdata = {28'd0, cfg_q.step_near};
			REG_STEP_MID:  prdata = {28'd0, cfg_q.step_mid};
			REG_STEP_FAR:  prdata = {28'd0, cfg_q.step_far};
			default:       prdata = 32'd0;
		endcase
	end

endmodule

### rtl/mppt_duty_tracker_core.sv
// Stage 1 holds v, i and the 16x16 power product; stage 2 compares against the
// tracked state and writes the result register once that is empty or its beat
// is taken. One sample is accepted per cycle while result_ready stays high.
// Reset (arst_n, async low): registers at their reset values, first sample
// pending, both pipeline stages empty.
// mppt_duty_tracker_core: top level; depends on mdt_pkg and mdt_regs.
module mppt_duty_tracker_core import mdt_pkg::*; #(
	parameter int DUTY_MIN     = 10,
	parameter int DUTY_MAX     = 90,
	parameter int NEAR_BAND_MV = 3000,
	parameter int MID_BAND_MV  = 5000
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  logic [15:0]       voltage_mv,
	input  logic [15:0]       current_ma,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [6:0]        duty_percent,
	output logic signed [1:0] direction
);

	localparam logic signed [8:0] DUTY_MIN_S = 9'(DUTY_MIN);
	localparam logic signed [8:0] DUTY_MAX_S = 9'(DUTY_MAX);
	localparam logic [15:0]       NEAR_BAND  = 16'(NEAR_BAND_MV);
	localparam logic [15:0]       MID_BAND   = 16'(MID_BAND_MV);

	cfg_t cfg;
	logic rearm;

	mdt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.rearm   (rearm)
	);

	logic        vld_s1;
	logic [15:0] volt_s1;
	logic [15:0] curr_s1;
	logic [31:0] pwr_s1;

	logic              res_vld_q;
	logic [6:0]        duty_q;
	logic signed [1:0] dir_q;

	logic [15:0] last_voltage_q;
	logic [15:0] last_current_q;
	logic [31:0] last_power_q;
	logic [6:0]  duty_now_q;
	logic        awaiting_first_q;

	logic advance;
	logic fire;

	assign advance      = !res_vld_q || result_ready;
	assign fire         = vld_s1 && advance;
	assign sample_ready = !vld_s1 || advance;
	assign result_valid = res_vld_q;
	assign duty_percent = duty_q;
	assign direction    = dir_q;

	// stage 1: capture and power product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (sample_ready) begin
			vld_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			volt_s1 <= voltage_mv;
			curr_s1 <= current_ma;
			pwr_s1  <= voltage_mv * current_ma;
		end
	end

	// stage 2: decision against tracked state
	logic [15:0]       lv, lc, v_dist;
	logic [31:0]       lp;
	logic [6:0]        dn;
	logic              v_gt, v_lt, i_gt, i_lt, p_gt, p_lt;
	logic [3:0]        step;
	logic signed [1:0] decision;
	logic signed [8:0] delta, duty_sum;
	logic [6:0]        duty_new;
	logic signed [1:0] dir_new;

	always_comb begin
		lv = awaiting_first_q ? volt_s1 : last_voltage_q;
		lc = awaiting_first_q ? curr_s1 : last_current_q;
		lp = awaiting_first_q ? pwr_s1  : last_power_q;
		if (awaiting_first_q) begin
			dn = (cfg.initial_duty < DUTY_FIRST_FLOOR) ? DUTY_FIRST_FLOOR : cfg.initial_duty;
		end else begin
			dn = duty_now_q;
		end

		v_gt = volt_s1 > lv;
		v_lt = volt_s1 < lv;
		i_gt = curr_s1 > lc;
		i_lt = curr_s1 < lc;
		p_gt = pwr_s1 > lp;
		p_lt = pwr_s1 < lp;

		v_dist = (volt_s1 >= cfg.optimum_voltage_mv) ? volt_s1 - cfg.optimum_voltage_mv
		                                             : cfg.optimum_voltage_mv - volt_s1;
		if (pwr_s1 > cfg.power_cutoff_uw) begin
			step = 4'd0;
		end else if (v_dist < NEAR_BAND) begin
			step = cfg.step_near;
		end else if (v_dist < MID_BAND) begin
			step = cfg.step_mid;
		end else begin
			step = cfg.step_far;
		end

		// inc-cond: decision = -sign(dI) when dV == 0, else -sign(dP)*sign(dV)
		if (cfg.mode == MODE_INC_COND) begin
			if (!v_gt && !v_lt) begin
				decision = i_gt ? DIR_DOWN : (i_lt ? DIR_UP : DIR_HOLD);
			end else if (!p_gt && !p_lt) begin
				decision = DIR_HOLD;
			end else begin
				decision = (p_gt == v_gt) ? DIR_DOWN : DIR_UP;
			end
		end else if (p_gt) begin
			decision = v_lt ? DIR_UP : DIR_DOWN;
		end else begin
			decision = v_gt ? DIR_UP : DIR_DOWN;
		end

		case (decision)
			DIR_UP:   delta = $signed({5'd0, step});
			DIR_DOWN: delta = -$signed({5'd0, step});
			default:  delta = 9'sd0;
		endcase
		duty_sum = $signed({2'b00, dn}) + delta;

		if (duty_sum > DUTY_MAX_S) begin
			duty_new = 7'(DUTY_MAX_S);
		end else if (duty_sum < DUTY_MIN_S) begin
			duty_new = 7'(DUTY_MIN_S);
		end else begin
			duty_new = duty_sum[6:0];
		end

		dir_new = (step == 4'd0) ? DIR_HOLD : decision;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			duty_q <= duty_new;
			dir_q  <= dir_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_voltage_q   <= 16'd0;
			last_current_q   <= 16'd0;
			last_power_q     <= 32'd0;
			duty_now_q       <= 7'd0;
			awaiting_first_q <= 1'b1;
		end else begin
			if (fire) begin
				last_voltage_q <= volt_s1;
				last_power_q   <= pwr_s1;
				duty_now_q     <= duty_new;
				// P&O keeps the current from the first sample
				if (cfg.mode == MODE_INC_COND || awaiting_first_q) begin
					last_current_q <= curr_s1;
				end
			end
			if (rearm) begin
				awaiting_first_q <= 1'b1;
			end else if (fire) begin
				awaiting_first_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_duty_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (duty_percent >= 7'(DUTY_MIN_S)) && (duty_percent <= 7'(DUTY_MAX_S)))
		else $error("duty out of clamp range");

	a_dir_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> direction != 2'sb10)
		else $error("illegal direction code");

	a_first_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !rearm) |=> !awaiting_first_q)
		else $error("first-sample flag not cleared");

	a_zero_step_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && step == 4'd0) |=> (direction == DIR_HOLD && duty_now_q == duty_percent))
		else $error("zero step moved direction");

	a_state_tracks_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> duty_now_q == duty_percent)
		else $error("duty state differs from result");
`endif

endmodule

### tb/sv/mppt_duty_tracker_core_tb.sv
// Testbench for mppt_duty_tracker_core: directed table then random phases, APB config
// between phases, random stalls on both streams, every result beat checked in order.
// Depends on mdt_pkg and mppt_duty_tracker_core.
`timescale 1ns / 100ps

module mppt_duty_tracker_core_tb;
	import mdt_pkg::*;

	localparam int DUTY_MIN     = 10;
	localparam int DUTY_MAX     = 90;
	localparam int NEAR_BAND_MV = 3000;
	localparam int MID_BAND_MV  = 5000;
	localparam int N_PHASES     = 16;
	localparam int PHASE_ITEMS  = 100;
	localparam int N_DIRECTED   = 31;
	localparam int LIMIT_CYCLES = 1000000;

	typedef struct packed {
		logic [6:0]        duty;
		logic signed [1:0] dir;
	} duty_beat_t;

	typedef enum logic [1:0] {
		ROW_SAMPLE,
		ROW_FIXED,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		reg_idx_t          idx;
		logic [31:0]       wdata;
		logic [15:0]       v;
		logic [15:0]       i;
		logic [6:0]        duty;
		logic signed [1:0] dir;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              sample_valid;
	logic              sample_ready;
	logic [15:0]       voltage_mv;
	logic [15:0]       current_ma;
	logic              result_valid;
	logic              result_ready;
	logic [6:0]        duty_percent;
	logic signed [1:0] direction;

	cfg_t        tracker_cfg = CFG_RESET;
	logic [15:0] held_v = '0;
	logic [15:0] held_i = '0;
	logic [31:0] held_p = '0;
	logic [6:0]  held_duty = '0;
	bit          first_pending = 1'b1;

	duty_beat_t  pending_duty[$];
	int          error_count = 0;
	int          cycle_count = 0;
	bit          calm = 1'b0;
	logic [15:0] walk_v = 16'd17800;
	logic [15:0] walk_i = 16'd5000;

	stim_row_t directed [0:N_DIRECTED-1] = '{
		'{ROW_FIXED,  REG_MODE,      32'd0,         16'd17800, 16'd1000,  7'd18, DIR_DOWN},
		'{ROW_SAMPLE, REG_MODE,      32'd0,         16'd0,     16'd0,     7'd0,  DIR_HOLD},
		'{ROW_FIXED,  REG_MODE,      32'd0,         16'hFFFF,  16'hFFFF,  7'd16, DIR_HOLD},
		'{ROW_WRITE,  REG_PWR_CUT,   32'hFFFF_FFFF, 16'd0,     16'd0,     7'd0,  DIR_HOLD},
		'{ROW_SAMPLE, REG_MODE,      32'd0,         16'hFFFF,  16'hFFFF,  7'd0,  DIR_HOLD},
		'{ROW_SAMPLE, REG_MODE,      32'd0,         16'd20000, 16'd100,   7'd0,  DIR_HOLD},
		'{ROW_SAMPLE, REG_MODE,      32'd0,         16'd19000, 16'd200,   7'd0,  DIR_HOLD},
		'{ROW_WRITE,  REG_MODE,      32'(MODE_INC_COND), 16'd0, 16'd0,    7'd0,  DIR_HOLD},
		'{ROW_SAMPLE, REG_MODE,      32'd0,         16'd19000, 16'd300,   7'd0,  DIR_HOLD},
		'{ROW_SAMPLE, REG_MODE,      32'd0,         16'd19500, 16'd300,   7'd0,  DIR_HOLD},
		'{ROW_SAMPLE, REG_MODE,      32'd0,         16'd19500, 16'd300,   7'd0,  DIR_HOLD},
		'{ROW_WRITE,  REG_STEP_NEAR, 32'd15,        16'd0,     16'd0,     7'd0,  DIR_HOLD},
		'{ROW_WRITE,  REG_STEP_MID,  32'd15,        16'd0,     16'd0,     7'd0,  DIR_HOLD},
		'{ROW_WRITE,  REG_STEP_FAR,  32'd15,        16'd0,     16'd0,     7'd0,  DIR_HOLD},
		'{ROW_WRITE,  REG_INIT_DUTY, 32'd0,         16'd0,     16'd0,     7'd0,  DIR_HOLD},
		'{ROW_FIXED,  REG_MODE,      32'd0,         16'd30000, 16'd100,   7'd20, DIR_HOLD},
		'{ROW_SAMPLE, REG_MODE,      32'd0,         16'd31000, 16'd100,   7'd0,  DIR_HOLD},
		'{ROW_FIXED,  REG_MODE,      32'd0,         16'd32000, 16'd100,   7'd10, DIR_DOWN},
		'{ROW_WRITE,  REG_MODE,      32'(MODE_PERTURB), 16'd0, 16'd0,     7'd0,  DIR_HOLD},
		'{ROW_WRITE,  REG_INIT_DUTY, 32'd127,       16'd0,     16'd0,     7'd0,  DIR_HOLD},
		'{ROW_FIXED,  REG_MODE,      32'd0,         16'd0,     16'hFFFF,  7'd90, DIR_DOWN},
		'{ROW_WRITE,  REG_OPT_VOLT,  32'd65535,     16'd0,     16'd0,     7'd0,  DIR_HOLD},
		'{ROW_WRITE,  REG_STEP_FAR,  32'd0,         16'd0,     16'd0,     7'd0,  DIR_HOLD},
		'{ROW_FIXED,  REG_MODE,      32'd0,         16'd0,     16'hFFFF,  7'd90, DIR_HOLD},
		'{ROW_WRITE,  REG_OPT_VOLT,  32'd10000,     16'd0,     16'd0,     7'd0,  DIR_HOLD},
		'{ROW_WRITE,  REG_STEP_MID,  32'd3,         16'd0,     16'd0,     7'd0,  DIR_HOLD},
		'{ROW_SAMPLE, REG_MODE,      32'd0,         16'd14000, 16'd1,     7'd0,  DIR_HOLD},
		'{ROW_SAMPLE, REG_MODE,      32'd0,         16'd7000,  16'd1,     7'd0,  DIR_HOLD},
		'{ROW_SAMPLE, REG_MODE,      32'd0,         16'd12999, 16'd1,     7'd0,  DIR_HOLD},
		'{ROW_SAMPLE, REG_MODE,      32'd0,         16'd5000,  16'd1,     7'd0,  DIR_HOLD},
		'{ROW_SAMPLE, REG_MODE,      32'd0,         16'd10000, 16'd0,     7'd0,  DIR_HOLD}
	};

	mppt_duty_tracker_core #(
		.DUTY_MIN(DUTY_MIN),
		.DUTY_MAX(DUTY_MAX),
		.NEAR_BAND_MV(NEAR_BAND_MV),
		.MID_BAND_MV(MID_BAND_MV)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.voltage_mv(voltage_mv),
		.current_ma(current_ma),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.duty_percent(duty_percent),
		.direction(direction)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic log_mismatch(input string msg);
		if (error_count < 50)
			$display("MISMATCH @%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic int sign_of(input longint x);
		return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
	endfunction

	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [15:0] extreme16();
		case ($urandom_range(0, 2))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// next duty for one sample; updates the tracked panel state
	task automatic track_sample(input logic [15:0] v, input logic [15:0] i,
			output duty_beat_t beat);
		logic [31:0] p;
		longint      dv, di, dp;
		int          v_dist, step, decision, duty;
		p = 32'(v) * 32'(i);
		if (first_pending) begin
			held_v = v;
			held_i = i;
			held_p = p;
			held_duty = (tracker_cfg.initial_duty < DUTY_FIRST_FLOOR) ?
				DUTY_FIRST_FLOOR : tracker_cfg.initial_duty;
			first_pending = 1'b0;
		end
		dv = longint'(v) - longint'(held_v);
		di = longint'(i) - longint'(held_i);
		dp = longint'(p) - longint'(held_p);
		v_dist = (v >= tracker_cfg.optimum_voltage_mv) ?
			int'(v - tracker_cfg.optimum_voltage_mv) :
			int'(tracker_cfg.optimum_voltage_mv - v);
		if (p > tracker_cfg.power_cutoff_uw)
			step = 0;
		else if (v_dist < NEAR_BAND_MV)
			step = int'(tracker_cfg.step_near);
		else if (v_dist < MID_BAND_MV)
			step = int'(tracker_cfg.step_mid);
		else
			step = int'(tracker_cfg.step_far);
		if (tracker_cfg.mode == MODE_INC_COND) begin
			decision = (dv == 0) ? -sign_of(di) : -(sign_of(dp) * sign_of(dv));
			held_i = i;
		end else if (dp > 0) begin
			decision = (dv < 0) ? 1 : -1;
		end else begin
			decision = (dv > 0) ? 1 : -1;
		end
		held_v = v;
		held_p = p;
		duty = int'(held_duty) + decision * step;
		if (duty > DUTY_MAX)
			duty = DUTY_MAX;
		if (duty < DUTY_MIN)
			duty = DUTY_MIN;
		held_duty = 7'(duty);
		beat.duty = held_duty;
		if (step == 0 || decision == 0)
			beat.dir = DIR_HOLD;
		else if (decision > 0)
			beat.dir = DIR_UP;
		else
			beat.dir = DIR_DOWN;
	endtask

	// called at a rising edge; returns at the edge the beat is accepted
	task automatic send_sample(input logic [15:0] v, input logic [15:0] i,
			input bit fixed, input duty_beat_t fixed_beat);
		duty_beat_t beat;
		int         gap;
		gap = idle_len();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		voltage_mv <= v;
		current_ma <= i;
		do @(posedge clk); while (!sample_ready);
		track_sample(v, i, beat);
		pending_duty.push_back(fixed ? fixed_beat : beat);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MODE: tracker_cfg.mode = mode_t'(val[0]);
			REG_INIT_DUTY: begin
				tracker_cfg.initial_duty = val[6:0];
				first_pending = 1'b1;
			end
			REG_PWR_CUT: tracker_cfg.power_cutoff_uw = val;
			REG_OPT_VOLT: tracker_cfg.optimum_voltage_mv = val[15:0];
			REG_STEP_NEAR: tracker_cfg.step_near = val[3:0];
			REG_STEP_MID: tracker_cfg.step_mid = val[3:0];
			REG_STEP_FAR: tracker_cfg.step_far = val[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_duty.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly small moves around the operating point, plus jumps and band edges
	task automatic roll_sample(output logic [15:0] v, output logic [15:0] i);
		int pick, offs;
		pick = $urandom_range(0, 99);
		v = walk_v;
		i = walk_i;
		if (pick < 40) begin
			v = walk_v + 16'($urandom_range(0, 400)) - 16'd200;
			i = walk_i + 16'($urandom_range(0, 100)) - 16'd50;
		end else if (pick < 50) begin
			i = walk_i + 16'($urandom_range(0, 100)) - 16'd50;
		end else if (pick < 60) begin
			v = walk_v;
		end else if (pick < 64) begin
			// same power at another point
			if (!walk_v[0] && !walk_i[15]) begin
				v = {1'b0, walk_v[15:1]};
				i = {walk_i[14:0], 1'b0};
			end
		end else if (pick < 78) begin
			v = 16'($urandom);
			i = 16'($urandom);
		end else if (pick < 86) begin
			v = extreme16();
			i = extreme16();
		end else begin
			case ($urandom_range(0, 4))
				0: offs = NEAR_BAND_MV - 1;
				1: offs = NEAR_BAND_MV;
				2: offs = MID_BAND_MV - 1;
				3: offs = MID_BAND_MV;
				default: offs = $urandom_range(0, 6000);
			endcase
			if ($urandom_range(0, 1))
				offs = -offs;
			v = tracker_cfg.optimum_voltage_mv + 16'(offs);
		end
		walk_v = v;
		walk_i = i;
	endtask

	always @(posedge clk) begin : result_check
		duty_beat_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_duty.size() == 0) begin
				log_mismatch($sformatf("unexpected beat duty=%0d dir=%0d",
					duty_percent, direction));
			end else begin
				want = pending_duty.pop_front();
				if (duty_percent !== want.duty)
					log_mismatch($sformatf("duty_percent %0d, want %0d",
						duty_percent, want.duty));
				if (direction !== want.dir)
					log_mismatch($sformatf("direction %0d, want %0d",
						direction, want.dir));
			end
		end
	end

	initial begin : result_stall
		int stall;
		result_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			stall = idle_len();
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		stim_row_t   row;
		logic [15:0] v, i;
		logic [31:0] cut;
		logic [15:0] opt;
		logic [3:0]  sn, sm, sf;
		logic [6:0]  idu;
		mode_t       md;
		int          r, phase, n;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_valid = 1'b0;
		voltage_mv = '0;
		current_ma = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < N_DIRECTED; r++) begin
			row = directed[r];
			if (row.kind == ROW_WRITE) begin
				sample_valid <= 1'b0;
				wait_drained();
				apb_write(row.idx, row.wdata);
			end else begin
				send_sample(row.v, row.i, row.kind == ROW_FIXED, '{row.duty, row.dir});
			end
		end

		for (phase = 0; phase < N_PHASES; phase++) begin
			sample_valid <= 1'b0;
			wait_drained();
			calm = (phase % 4 == 3);
			if (phase == 1) begin
				md = MODE_PERTURB;
				cut = '1;
				opt = '1;
				sn = '1;
				sm = '1;
				sf = '1;
				idu = '1;
			end else if (phase == 2) begin
				md = MODE_INC_COND;
				cut = '0;
				opt = '0;
				sn = '0;
				sm = '0;
				sf = '0;
				idu = '0;
			end else begin
				md = mode_t'($urandom_range(0, 1));
				case ($urandom_range(0, 3))
					0: cut = 32'd95000000;
					1: cut = $urandom;
					2: cut = 32'(walk_v) * 32'(walk_i) + $urandom_range(0, 2000000) - 1000000;
					default: cut = $urandom_range(0, 200000000);
				endcase
				case ($urandom_range(0, 2))
					0: opt = 16'd17800;
					1: opt = walk_v + 16'($urandom_range(0, 10000)) - 16'd5000;
					default: opt = 16'($urandom);
				endcase
				sn = 4'($urandom);
				sm = 4'($urandom);
				sf = 4'($urandom);
				idu = 7'($urandom);
			end
			apb_write(REG_MODE, 32'(md));
			apb_write(REG_PWR_CUT, cut);
			apb_write(REG_OPT_VOLT, 32'(opt));
			apb_write(REG_STEP_NEAR, 32'(sn));
			apb_write(REG_STEP_MID, 32'(sm));
			apb_write(REG_STEP_FAR, 32'(sf));
			if (phase < 3 || $urandom_range(0, 1))
				apb_write(REG_INIT_DUTY, 32'(idu));
			for (n = 0; n < PHASE_ITEMS; n++) begin
				roll_sample(v, i);
				send_sample(v, i, 1'b0, '{7'd0, DIR_HOLD});
			end
		end

		sample_valid <= 1'b0;
		n = 0;
		while (pending_duty.size() != 0 && n < 2000) begin
			@(posedge clk);
			n++;
		end
		repeat (8) @(posedge clk);
		if (pending_duty.size() != 0)
			log_mismatch($sformatf("%0d expected beats never arrived", pending_duty.size()));
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
